### rtl/dci_pkg.sv
// Shared types and constants for the drive controller with obstacle interlock.
// No dependencies; every other rtl file refers to this package by scoped name.
`default_nettype none

package dci_pkg;

   // field widths
   localparam int OP_W       = 4;
   localparam int SPEED_W    = 8;
   localparam int ECHO_W     = 21;
   localparam int LIMIT_W    = 10;
   localparam int PINS_W     = 8;
   localparam int DUTY_W     = 7;
   localparam int SERVO_W    = 8;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 21;

   // echo scaling: distance = t_us * 17150 / 1e6 cm
   localparam int CM_PER_S   = 17150;
   localparam int US_PER_S   = 1000000;
   localparam int SCALE_W    = 15;                  // 17150 < 2**15
   localparam int SCALED_W   = ECHO_W + SCALE_W;

   localparam int WINDOW_DEF = 9;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_NEAR    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FAR     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT = 2'd2;

   // register reset values
   localparam logic [LIMIT_W-1:0] NEAR_RST    = 10'd40;
   localparam logic [LIMIT_W-1:0] FAR_RST     = 10'd75;
   localparam logic [ECHO_W-1:0]  TIMEOUT_RST = 21'd1500000;

   // bridge pin patterns, LT pair in the top bits
   localparam logic [PINS_W-1:0] PINS_FWD      = 8'hAA;
   localparam logic [PINS_W-1:0] PINS_REV      = 8'h55;
   localparam logic [PINS_W-1:0] PINS_LEFT     = 8'h6A;
   localparam logic [PINS_W-1:0] PINS_RIGHT    = 8'h9A;
   localparam logic [PINS_W-1:0] PINS_REV_LEFT = 8'h59;
   localparam logic [PINS_W-1:0] PINS_REV_RGHT = 8'h56;

   localparam logic [SERVO_W-1:0] SERVO_RIGHT = 8'd13;
   localparam logic [SERVO_W-1:0] SERVO_LEFT  = 8'd17;
   localparam logic [SERVO_W-1:0] SERVO_OFF   = 8'd0;

   localparam logic [DUTY_W-1:0] DUTY_MAX  = 7'd100;
   localparam logic [DUTY_W-1:0] DUTY_STEP = 7'd10;

   typedef enum logic [OP_W-1:0] {
      OP_FWD        = 4'd0,
      OP_REV        = 4'd1,
      OP_LEFT       = 4'd2,
      OP_RIGHT      = 4'd3,
      OP_STOP       = 4'd4,
      OP_SET_SPEED  = 4'd5,
      OP_SPEED_UP   = 4'd6,
      OP_SLOW_DOWN  = 4'd7,
      OP_CAM_RIGHT  = 4'd8,
      OP_CAM_LEFT   = 4'd9,
      OP_CAM_STOP   = 4'd10,
      OP_FRONT_ECHO = 4'd11,
      OP_REAR_ECHO  = 4'd12
   } op_type;

   typedef enum logic [1:0] {
      MS_STOPPED = 2'd0,
      MS_MOVING  = 2'd1,
      MS_FORWARD = 2'd2,
      MS_REVERSE = 2'd3
   } motion_type;

   // interlock status from the two echo trackers to the motion unit
   typedef struct packed {
      logic front_ok;
      logic rear_ok;
      logic front_stop;
      logic rear_stop;
   } interlock_type;

   // drive state shown on the result channel
   typedef struct packed {
      motion_type          motion;
      logic [SERVO_W-1:0]  servo;
      logic [DUTY_W-1:0]   duty;
      logic [PINS_W-1:0]   pins;
   } drive_status_type;

endpackage

`default_nettype wire

### rtl/dci_echo_side.sv
// Echo tracker for one sensor side: ring of scaled echo times, running sum,
// window compare and interlock flag. Uses dci_pkg.
`default_nettype none

module dci_echo_side #(
   parameter int WINDOW = dci_pkg::WINDOW_DEF,
   parameter int SUM_W  = dci_pkg::SCALED_W + $clog2(WINDOW + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          echo_en,     // kept echo for this side
   input  wire logic [dci_pkg::SCALED_W-1:0]  echo_scaled, // t_us * 17150
   input  wire logic [SUM_W-1:0]              lo_thresh,
   input  wire logic [SUM_W-1:0]              hi_thresh,
   output logic                               ok,
   output logic                               stop_req
);

   localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

   logic [dci_pkg::SCALED_W-1:0] hist_ff [WINDOW];
   logic [PTR_W-1:0]             ptr_ff, ptr_in;
   logic                         full_ff, full_in;
   logic [SUM_W-1:0]             sum_ff, sum_in;
   logic                         ok_ff, ok_in;
   logic                         outside;

   always_comb begin
      if (full_ff) begin
         sum_in = sum_ff - SUM_W'(hist_ff[ptr_ff]) + SUM_W'(echo_scaled);
      end else begin
         sum_in = sum_ff + SUM_W'(echo_scaled);
      end
      outside  = (sum_in < lo_thresh) || (sum_in > hi_thresh);
      ptr_in   = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
      full_in  = full_ff || (ptr_ff == PTR_LAST);
      ok_in    = ok_ff;
      stop_req = 1'b0;
      if (echo_en && full_ff) begin
         if (outside) begin
            stop_req = ok_ff;
            ok_in    = 1'b0;
         end else begin
            ok_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         full_ff <= 1'b0;
         sum_ff  <= '0;
         ok_ff   <= 1'b1;
      end else if (echo_en) begin
         ptr_ff  <= ptr_in;
         full_ff <= full_in;
         sum_ff  <= sum_in;
         ok_ff   <= ok_in;
      end
   end

   // history needs no reset: read only once every slot was written
   always_ff @(posedge clock) begin
      if (echo_en) begin
         hist_ff[ptr_ff] <= echo_scaled;
      end
   end

   assign ok = ok_ff;

endmodule

`default_nettype wire

### rtl/dci_motion.sv
// Motion, speed, bridge pattern and camera servo state for one command per beat.
// Uses dci_pkg; interlock flags and stop requests come from dci_echo_side.
`default_nettype none

module dci_motion (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         cmd_en,
   input  wire dci_pkg::op_type              cmd_op,
   input  wire logic [dci_pkg::SPEED_W-1:0]  speed_value,
   input  wire dci_pkg::interlock_type       lock,
   output dci_pkg::drive_status_type         status
);

   dci_pkg::motion_type                motion_ff, motion_in;
   logic [dci_pkg::DUTY_W-1:0]         duty_ff, duty_in;
   logic [dci_pkg::PINS_W-1:0]         pins_ff, pins_in;
   logic [dci_pkg::SERVO_W-1:0]        servo_ff, servo_in;
   logic                               in_rev;
   logic [dci_pkg::DUTY_W:0]           duty_up;

   always_comb begin
      motion_in = motion_ff;
      duty_in   = duty_ff;
      pins_in   = pins_ff;
      servo_in  = servo_ff;
      in_rev    = (motion_ff == dci_pkg::MS_REVERSE);
      duty_up   = {1'b0, duty_ff} + {1'b0, dci_pkg::DUTY_STEP};
      unique case (cmd_op)
         dci_pkg::OP_FWD: begin
            if (lock.front_ok) begin
               pins_in   = dci_pkg::PINS_FWD;
               motion_in = dci_pkg::MS_FORWARD;
            end
         end
         dci_pkg::OP_REV: begin
            if (lock.rear_ok) begin
               pins_in   = dci_pkg::PINS_REV;
               motion_in = dci_pkg::MS_REVERSE;
            end
         end
         dci_pkg::OP_LEFT, dci_pkg::OP_RIGHT: begin
            // turns follow the current direction; from stopped they start moving
            if (in_rev ? lock.rear_ok : lock.front_ok) begin
               if (cmd_op == dci_pkg::OP_LEFT) begin
                  pins_in = in_rev ? dci_pkg::PINS_REV_LEFT : dci_pkg::PINS_LEFT;
               end else begin
                  pins_in = in_rev ? dci_pkg::PINS_REV_RGHT : dci_pkg::PINS_RIGHT;
               end
               if (motion_ff == dci_pkg::MS_STOPPED) begin
                  motion_in = dci_pkg::MS_MOVING;
               end
            end
         end
         dci_pkg::OP_STOP: motion_in = dci_pkg::MS_STOPPED;
         dci_pkg::OP_SET_SPEED: begin
            if (speed_value <= dci_pkg::SPEED_W'(dci_pkg::DUTY_MAX)) begin
               duty_in = speed_value[dci_pkg::DUTY_W-1:0];
            end
         end
         dci_pkg::OP_SPEED_UP: begin
            duty_in = (duty_up > {1'b0, dci_pkg::DUTY_MAX}) ? dci_pkg::DUTY_MAX
                                                           : duty_up[dci_pkg::DUTY_W-1:0];
         end
         dci_pkg::OP_SLOW_DOWN: begin
            duty_in = (duty_ff < dci_pkg::DUTY_STEP) ? '0 : duty_ff - dci_pkg::DUTY_STEP;
         end
         dci_pkg::OP_CAM_RIGHT: servo_in = dci_pkg::SERVO_RIGHT;
         dci_pkg::OP_CAM_LEFT:  servo_in = dci_pkg::SERVO_LEFT;
         dci_pkg::OP_CAM_STOP:  servo_in = dci_pkg::SERVO_OFF;
         dci_pkg::OP_FRONT_ECHO: begin
            if (lock.front_stop && (motion_ff == dci_pkg::MS_FORWARD)) begin
               motion_in = dci_pkg::MS_STOPPED;
            end
         end
         dci_pkg::OP_REAR_ECHO: begin
            if (lock.rear_stop && (motion_ff == dci_pkg::MS_REVERSE)) begin
               motion_in = dci_pkg::MS_STOPPED;
            end
         end
         default: ;  // unused opcodes
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_ff <= dci_pkg::MS_STOPPED;
         duty_ff   <= dci_pkg::DUTY_MAX;
         pins_ff   <= '0;
         servo_ff  <= dci_pkg::SERVO_OFF;
      end else if (cmd_en) begin
         motion_ff <= motion_in;
         duty_ff   <= duty_in;
         pins_ff   <= pins_in;
         servo_ff  <= servo_in;
      end
   end

   assign status.motion = motion_ff;
   assign status.servo  = servo_ff;
   assign status.duty   = duty_ff;
   assign status.pins   = pins_ff;

endmodule

`default_nettype wire

### rtl/drive_control_with_obstacle_interlock_top.sv
// Top level of the four-wheel drive controller with front/rear obstacle interlock.
// Uses dci_pkg, dci_echo_side (one per sensor) and dci_motion.
// Usage:
//  - req_* : command beats (opcode, set-speed value, echo time in us).
//  - rsp_* : one status beat per command: bridge pins, drive enable, duty,
//            servo value, motion state and the two interlock flags, all as they
//            stand after that command.
//  - csr_* : write-only registers (near limit, far limit, echo timeout); write
//            only while no command is in flight.
// A beat is accepted into the input stage, which holds the echo scale multiply
// (t * 17150); on advance it loads the drive state and rsp_tvalid. Throughput:
// one command per cycle while rsp_tready is high; the echo path (ring read,
// running-sum add/subtract, window compare, stop decision) sets the period.
// The status registers are the drive state itself, so the result needs no
// separate copy: state only advances when the result slot is free or drained.
// Stall: when rsp_tready is low, one more command can sit in the input stage;
// after that req_tready drops. Nothing is dropped or repeated.
// Reset (synchronous, active high): stopped, duty 100, pins 0, servo 0, both
// interlocks open, echo history empty, registers at 40 / 75 / 1500000.
// Interlock compare is exact: sum(t*17150) against limit * WINDOW * 1e6.
`default_nettype none

module drive_control_with_obstacle_interlock_top #(
   parameter int WINDOW = dci_pkg::WINDOW_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // command channel
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [39:0]                     req_tdata,  // opcode[3:0], speed_value[11:4],
                                                           // echo_time_us[32:12], zero fill
   // status channel
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [31:0]                          rsp_tdata,  // bridge_pins[7:0], drive_on[8],
                                                           // duty_percent[15:9],
                                                           // servo_duty[23:16],
                                                           // motion_state[25:24],
                                                           // forward_allowed[26],
                                                           // reverse_allowed[27], zero fill
   // register writes
   input  wire logic                            csr_we,
   input  wire logic [dci_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [dci_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SUM_W = dci_pkg::SCALED_W + $clog2(WINDOW + 1);
   // limit in cm times WINDOW * 1e6, compared against sum of t*17150
   localparam logic [SUM_W-1:0] LIM_SCALE = SUM_W'(WINDOW * dci_pkg::US_PER_S);
   localparam logic [SUM_W-1:0] LO_RST    = SUM_W'(dci_pkg::NEAR_RST) * LIM_SCALE;
   localparam logic [SUM_W-1:0] HI_RST    = SUM_W'(dci_pkg::FAR_RST) * LIM_SCALE;

   // ---------------- configuration ----------------
   // limits kept pre-scaled so the echo path has no multiplier
   logic [SUM_W-1:0]              lo_thresh_ff;
   logic [SUM_W-1:0]              hi_thresh_ff;
   logic [dci_pkg::ECHO_W-1:0]    timeout_ff;
   logic [SUM_W-1:0]              limit_scaled;

   assign limit_scaled = SUM_W'(csr_wdata[dci_pkg::LIMIT_W-1:0]) * LIM_SCALE;

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_thresh_ff <= LO_RST;
         hi_thresh_ff <= HI_RST;
         timeout_ff   <= dci_pkg::TIMEOUT_RST;
      end else if (csr_we) begin
         if (csr_addr == dci_pkg::CSR_NEAR) begin
            lo_thresh_ff <= limit_scaled;
         end else if (csr_addr == dci_pkg::CSR_FAR) begin
            hi_thresh_ff <= limit_scaled;
         end else if (csr_addr == dci_pkg::CSR_TIMEOUT) begin
            timeout_ff <= csr_wdata[dci_pkg::ECHO_W-1:0];
         end
      end
   end

   // ---------------- input stage ----------------
   logic                             s1_valid_ff;
   dci_pkg::op_type                  s1_op_ff;
   logic [dci_pkg::SPEED_W-1:0]      s1_speed_ff;
   logic [dci_pkg::SCALED_W-1:0]     s1_scaled_ff;
   logic                             s1_keep_ff;   // echo under timeout

   logic                             out_valid_ff, out_valid_in;
   logic                             advance;
   logic [dci_pkg::ECHO_W-1:0]       echo_in;
   logic [dci_pkg::SCALED_W-1:0]     echo_scaled_in;

   assign echo_in        = req_tdata[32:12];
   assign echo_scaled_in = dci_pkg::SCALED_W'(echo_in)
                         * dci_pkg::SCALED_W'(dci_pkg::CM_PER_S);

   // input stage moves on when the status slot is empty or being read
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_op_ff     <= dci_pkg::op_type'(req_tdata[3:0]);
         s1_speed_ff  <= req_tdata[11:4];
         s1_scaled_ff <= echo_scaled_in;
         s1_keep_ff   <= (echo_in < timeout_ff);
      end
   end

   // ---------------- echo trackers ----------------
   dci_pkg::interlock_type  lock;
   logic                    front_en, rear_en;
   logic                    front_ok, rear_ok;
   logic                    front_stop, rear_stop;

   assign front_en = advance && s1_keep_ff && (s1_op_ff == dci_pkg::OP_FRONT_ECHO);
   assign rear_en  = advance && s1_keep_ff && (s1_op_ff == dci_pkg::OP_REAR_ECHO);

   dci_echo_side #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .echo_en     (front_en),
      .echo_scaled (s1_scaled_ff),
      .lo_thresh   (lo_thresh_ff),
      .hi_thresh   (hi_thresh_ff),
      .ok          (front_ok),
      .stop_req    (front_stop)
   );

   dci_echo_side #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_rear (
      .clock       (clock),
      .reset       (reset),
      .echo_en     (rear_en),
      .echo_scaled (s1_scaled_ff),
      .lo_thresh   (lo_thresh_ff),
      .hi_thresh   (hi_thresh_ff),
      .ok          (rear_ok),
      .stop_req    (rear_stop)
   );

   assign lock = {front_ok, rear_ok, front_stop, rear_stop};

   // ---------------- motion state ----------------
   dci_pkg::drive_status_type  status;

   dci_motion u_motion (
      .clock       (clock),
      .reset       (reset),
      .cmd_en      (advance),
      .cmd_op      (s1_op_ff),
      .speed_value (s1_speed_ff),
      .lock        (lock),
      .status      (status)
   );

   // ---------------- status channel ----------------
   // state registers double as the result register; they hold while stalled
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        lock.rear_ok,
                        lock.front_ok,
                        status.motion,
                        status.servo,
                        status.duty,
                        (status.motion != dci_pkg::MS_STOPPED),
                        status.pins};

endmodule

`default_nettype wire
